/* sv/assert_macros.svh */
// Shared assertion macros, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Assert that a consequent follows an antecedent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/isort_pkg.sv */
package isort_pkg;

	localparam int WORD_W = 32;
	localparam int DEPTH_DEF = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Broadcast command to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

/* sv/isort_in_if.sv */
interface isort_in_if import isort_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t value;
	logic  last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

/* sv/isort_out_if.sv */
interface isort_out_if import isort_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t sorted_value;
	logic  is_last;
	logic  dropped;

	modport source (output valid, output sorted_value, output is_last, output dropped,
		input ready);
	modport sink (input valid, input sorted_value, input is_last, input dropped,
		output ready);
endinterface

/* sv/isort_cell.sv */
module isort_cell import isort_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  word_t      din,
	input  logic       left_valid,
	input  logic       left_gt,
	input  word_t      left_val,
	input  logic       right_valid,
	input  word_t      right_val,
	output logic       valid,
	output logic       gt,
	output word_t      val
);

	logic  valid_q;
	word_t val_q;

	assign gt = valid_q && (val_q > din);
	assign valid = valid_q;
	assign val = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.ins) begin
			if (left_gt || ((gt || !valid_q) && left_valid)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= right_val;
		end else if (ctrl.ins) begin
			// shift up past the new word, or take it at the insertion point
			if (left_gt) begin
				val_q <= left_val;
			end else if ((gt || !valid_q) && left_valid) begin
				val_q <= din;
			end
		end
	end

endmodule

/* sv/insertion_sort_engine_top.sv */
// Streaming insertion sorter for signed 32-bit words.
// in_ch carries value and last; out_ch carries sorted_value, is_last and
// dropped. A word moves on either channel when valid and ready are both high.
// Loading: one word per cycle while in_ch.ready is high. Each word is
// broadcast to a chain of DEPTH compare-and-shift cells and lands in its
// ordered slot in the cycle it is accepted; equal words keep arrival order.
// Words arriving with the chain full are discarded and dropped is raised on
// every result of that set. A word with last set closes the set. The chain
// then shifts toward the output register one slot per cycle while out_ch is
// not stalled: the first result becomes valid once drain_q is set and the
// head word is popped into the output register. in_ch.ready is low during
// this drain. The output register parts the sides: the next set loads while
// the final result still waits. A stall on out_ch holds the register and
// freezes the draining chain. Reset empties the chain, clears the overflow
// flag and the output valid.
module insertion_sort_engine_top import isort_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	isort_in_if.sink     in_ch,
	isort_out_if.source  out_ch
);

	logic [DEPTH-1:0] vld;
	logic [DEPTH-1:0] gt;
	word_t            val [DEPTH];

	cell_ctrl_t ctrl;
	logic       in_acc;
	logic       full;
	logic       pop;
	logic       pop_last;
	logic       drain_q;
	logic       ovf_q;
	logic       out_valid_q;
	word_t      out_val_q;
	logic       out_last_q;
	logic       out_drop_q;

	assign full = vld[DEPTH-1];
	assign in_ch.ready = !drain_q;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign pop = drain_q && vld[0] && (!out_valid_q || out_ch.ready);
	assign pop_last = pop && !vld[1];
	assign ctrl.ins = in_acc && !full;
	assign ctrl.pop = pop;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic  lv;
		logic  lg;
		word_t lval;
		logic  rv;
		word_t rval;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign lg = 1'b0;
			assign lval = in_ch.value;
		end else begin : g_body
			assign lv = vld[i-1];
			assign lg = gt[i-1];
			assign lval = val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rval = val[i];
		end else begin : g_mid
			assign rv = vld[i+1];
			assign rval = val[i+1];
		end

		isort_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.din         (in_ch.value),
			.left_valid  (lv),
			.left_gt     (lg),
			.left_val    (lval),
			.right_valid (rv),
			.right_val   (rval),
			.valid       (vld[i]),
			.gt          (gt[i]),
			.val         (val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_last) begin
				drain_q <= 1'b0;
			end else if (in_acc && in_ch.last) begin
				drain_q <= 1'b1;
			end
			// drop on a full chain, clear once the set has drained
			if (pop_last) begin
				ovf_q <= 1'b0;
			end else if (in_acc && full) begin
				ovf_q <= 1'b1;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_val_q <= val[0];
			out_last_q <= !vld[1];
			out_drop_q <= ovf_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.sorted_value = out_val_q;
	assign out_ch.is_last = out_last_q;
	assign out_ch.dropped = out_drop_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_vld_contig, (vld & (vld + DEPTH'(1))) == '0, "chain has a hole")
	`ASSERT_ALWAYS(a_ovf_full, (ovf_q && !drain_q) -> vld[DEPTH-1], "overflow without full chain")
	`ASSERT_NEXT(a_last_drain, in_acc && in_ch.last, drain_q, "drain not started")
	`ASSERT_NEXT(a_drain_end, pop_last, !drain_q && !vld[0], "drain did not end empty")

endmodule
